// ===== rtl/bmsf_pkg.sv =====
// ============================================================================
// bmsf_pkg - shared types and constants of the block median sample filter
// Field widths, configuration register indexes and reset values.
// ============================================================================
`default_nettype none

package bmsf_pkg;

    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 10;
    localparam int PERIOD_W   = 16;
    localparam int RANK_W     = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [TIME_W-1:0]          time_t;
    typedef logic [PERIOD_W-1:0]        period_t;
    typedef logic [RANK_W-1:0]          rank_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_SAMPLE_PERIOD = cfg_idx_t'(0);
    localparam cfg_idx_t REG_SELECT_RANK   = cfg_idx_t'(1);

    // Register reset values
    localparam period_t PERIOD_RESET = period_t'(1000);
    localparam rank_t   RANK_RESET   = rank_t'(2);

endpackage : bmsf_pkg

`default_nettype wire

// ===== rtl/block_median_sample_filter.sv =====
// ============================================================================
// block_median_sample_filter - rank-selecting filter over batches of samples
// Gates ticks by a sample period, batches accepted readings in a small
// synchronous memory and picks the sample of a configured rank per batch.
// ============================================================================
// Each tick beat carries the millisecond time and a sensor reading, and every
// tick beat produces exactly one result beat. A reading is taken when the
// wrapping 32-bit time since the last taken sample reaches sample_period_ms;
// it then becomes raw_value and is written into a BATCH_SIZE-entry sample
// memory. When the memory is already full, the taken reading is not stored:
// instead the stored samples are ranked, the one at select_rank (clamped to
// BATCH_SIZE-1) becomes filtered_value, and the batch starts over. Timing:
// the result of a tick that does not close a batch is registered and is
// valid in the cycle after the accept. A tick that closes a batch holds
// its result until the rank search ends: the search walks the candidates in
// turn and, for each, reads the whole batch through the memory's single
// read port, counting smaller and equal samples; it stops at the first
// candidate whose rank window covers select_rank. A new tick is taken in
// the cycle the previous result beat leaves or any time after. The result
// sits in an output register, so a stalled result beat does not hold off
// configuration writes, which are always ready and should only be issued
// while no tick is in flight.
`default_nettype none

module block_median_sample_filter #(
    parameter int BATCH_SIZE = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    // Tick channel
    input  wire logic                tick_valid,
    output logic                     tick_ready,
    input  wire bmsf_pkg::time_t     time_ms,
    input  wire bmsf_pkg::sample_t   reading,

    // Result channel
    output logic                     result_valid,
    input  wire logic                result_ready,
    output bmsf_pkg::sample_t        filtered_value,
    output bmsf_pkg::sample_t        raw_value,
    output logic                     sample_taken,
    output logic                     batch_done,

    // Configuration write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire bmsf_pkg::cfg_idx_t  cfg_index,
    input  wire bmsf_pkg::cfg_data_t cfg_data
);

    import bmsf_pkg::*;

    localparam int IDX_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
    localparam int CNT_W = $clog2(BATCH_SIZE + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BATCH_SIZE - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BATCH_SIZE);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // wait for a tick
    localparam logic [1:0] ST_CAND  = 2'd1;  // read the current candidate
    localparam logic [1:0] ST_LATCH = 2'd2;  // capture candidate, start scan
    localparam logic [1:0] ST_SCAN  = 2'd3;  // stream the batch, count ranks

    // ------------------------------------------------------------------
    // Sample memory: one write port, one registered read port
    // ------------------------------------------------------------------
    sample_t             mem [BATCH_SIZE];
    sample_t             rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_wr_addr;
    logic [IDX_W-1:0]    mem_rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= reading;
        end
        rd_data_reg <= mem[mem_rd_addr];
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [1:0]          state_reg,        state_next;
    period_t             period_reg,       period_next;
    rank_t               rank_reg,         rank_next;
    time_t               last_accept_reg,  last_accept_next;
    logic [CNT_W-1:0]    fill_count_reg,   fill_count_next;
    sample_t             filtered_reg,     filtered_next;
    sample_t             raw_reg,          raw_next;

    logic [IDX_W-1:0]    cand_idx_reg,     cand_idx_next;
    sample_t             cand_val_reg,     cand_val_next;
    logic [IDX_W-1:0]    scan_idx_reg,     scan_idx_next;
    logic [CNT_W-1:0]    lt_cnt_reg,       lt_cnt_next;
    logic [CNT_W-1:0]    eq_cnt_reg,       eq_cnt_next;

    logic                result_valid_reg, result_valid_next;
    sample_t             out_filtered_reg, out_filtered_next;
    sample_t             out_raw_reg,      out_raw_next;
    logic                out_taken_reg,    out_taken_next;
    logic                out_done_reg,     out_done_next;

    // ------------------------------------------------------------------
    // Datapath terms
    // ------------------------------------------------------------------
    logic                tick_fire;
    time_t               elapsed;
    logic                sample_ok;
    logic                batch_full;
    logic [IDX_W-1:0]    rank_sel;
    logic [CNT_W-1:0]    rank_cnt;
    logic [CNT_W-1:0]    lt_sum;
    logic [CNT_W-1:0]    eq_sum;
    logic                rank_hit;
    logic                scan_last;
    logic                cand_last;

    assign tick_ready = (state_reg == ST_IDLE) && (!result_valid_reg || result_ready);
    assign tick_fire  = tick_valid && tick_ready;
    assign cfg_ready  = 1'b1;

    // Wrapping difference handles time rollover for free
    assign elapsed    = time_ms - last_accept_reg;
    assign sample_ok  = elapsed >= TIME_W'(period_reg);
    assign batch_full = fill_count_reg == FULL_CNT;

    // Clamp an out-of-range rank to the top of the batch
    assign rank_sel   = (32'(rank_reg) >= BATCH_SIZE) ? LAST_IDX : IDX_W'(rank_reg);
    assign rank_cnt   = CNT_W'(rank_sel);

    // Running counts including the sample arriving this cycle. The candidate
    // sits at positions [lt, lt+eq) of the sorted batch; ties share the value.
    assign lt_sum     = lt_cnt_reg + CNT_W'(rd_data_reg < cand_val_reg);
    assign eq_sum     = eq_cnt_reg + CNT_W'(rd_data_reg == cand_val_reg);
    assign rank_hit   = (lt_sum <= rank_cnt) && (rank_cnt < CNT_W'(lt_sum + eq_sum));
    assign scan_last  = scan_idx_reg == LAST_IDX;
    assign cand_last  = cand_idx_reg == LAST_IDX;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        period_next       = period_reg;
        rank_next         = rank_reg;
        last_accept_next  = last_accept_reg;
        fill_count_next   = fill_count_reg;
        filtered_next     = filtered_reg;
        raw_next          = raw_reg;
        cand_idx_next     = cand_idx_reg;
        cand_val_next     = cand_val_reg;
        scan_idx_next     = scan_idx_reg;
        lt_cnt_next       = lt_cnt_reg;
        eq_cnt_next       = eq_cnt_reg;
        out_filtered_next = out_filtered_reg;
        out_raw_next      = out_raw_reg;
        out_taken_next    = out_taken_reg;
        out_done_next     = out_done_reg;
        mem_we            = 1'b0;
        mem_wr_addr       = fill_count_reg[IDX_W-1:0];
        mem_rd_addr       = cand_idx_reg;

        // Drop the result once the sink takes it
        result_valid_next = result_valid_reg && !result_ready;

        // Configuration writes; unknown indexes are ignored
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SAMPLE_PERIOD: period_next = cfg_data;
                REG_SELECT_RANK:   rank_next   = cfg_data[RANK_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_fire)
                begin
                    result_valid_next = 1'b1;
                    out_filtered_next = filtered_reg;
                    out_raw_next      = sample_ok ? reading : raw_reg;
                    out_taken_next    = sample_ok;
                    out_done_next     = 1'b0;
                    if (sample_ok)
                    begin
                        last_accept_next = time_ms;
                        raw_next         = reading;
                        if (batch_full)
                        begin
                            // Hold the result until the rank search ends
                            result_valid_next = 1'b0;
                            fill_count_next   = '0;
                            cand_idx_next     = '0;
                            state_next        = ST_CAND;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            fill_count_next = fill_count_reg + 1'b1;
                        end
                    end
                end
            end

            ST_CAND:
            begin
                mem_rd_addr = cand_idx_reg;
                state_next  = ST_LATCH;
            end

            ST_LATCH:
            begin
                cand_val_next = rd_data_reg;
                mem_rd_addr   = '0;
                scan_idx_next = '0;
                lt_cnt_next   = '0;
                eq_cnt_next   = '0;
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                mem_rd_addr   = scan_last ? '0 : scan_idx_reg + 1'b1;
                lt_cnt_next   = lt_sum;
                eq_cnt_next   = eq_sum;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_last)
                begin
                    if (rank_hit || cand_last)
                    begin
                        filtered_next     = cand_val_reg;
                        out_filtered_next = cand_val_reg;
                        out_raw_next      = raw_reg;
                        out_taken_next    = 1'b1;
                        out_done_next     = 1'b1;
                        result_valid_next = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        // Advance to the next candidate
                        cand_idx_next = cand_idx_reg + 1'b1;
                        state_next    = ST_CAND;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            period_reg       <= PERIOD_RESET;
            rank_reg         <= RANK_RESET;
            last_accept_reg  <= '0;
            fill_count_reg   <= '0;
            filtered_reg     <= '0;
            raw_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            period_reg       <= period_next;
            rank_reg         <= rank_next;
            last_accept_reg  <= last_accept_next;
            fill_count_reg   <= fill_count_next;
            filtered_reg     <= filtered_next;
            raw_reg          <= raw_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: search scratch and the output stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cand_idx_reg     <= cand_idx_next;
        cand_val_reg     <= cand_val_next;
        scan_idx_reg     <= scan_idx_next;
        lt_cnt_reg       <= lt_cnt_next;
        eq_cnt_reg       <= eq_cnt_next;
        out_filtered_reg <= out_filtered_next;
        out_raw_reg      <= out_raw_next;
        out_taken_reg    <= out_taken_next;
        out_done_reg     <= out_done_next;
    end

    assign result_valid   = result_valid_reg;
    assign filtered_value = out_filtered_reg;
    assign raw_value      = out_raw_reg;
    assign sample_taken   = out_taken_reg;
    assign batch_done     = out_done_reg;

endmodule : block_median_sample_filter

`default_nettype wire

// ===== tb/sv/block_median_sample_filter_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// block_median_sample_filter_test - self-checking bench of the median filter
// Drives tick beats with random idling and result back-pressure, predicts
// every result beat from a private model of the filter, and compares each
// result field by field across several period and rank settings.
// ============================================================================

module block_median_sample_filter_test;

    import bmsf_pkg::*;

    localparam int BATCH_N         = 5;
    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 66;
    // Extra idle clocks after the final drain, longer than the longest batch close.
    localparam int SETTLE_CYCLES   = 40;

    localparam sample_t  SAMPLE_MIN = sample_t'(-512);
    localparam sample_t  SAMPLE_MAX = sample_t'(511);
    localparam cfg_idx_t REG_TOP    = cfg_idx_t'(8'hFF);

    // One expected result beat.
    typedef struct {
        sample_t filt;
        sample_t raw;
        logic    taken;
        logic    done;
    } filter_result_t;

    // ------------------------------------------------------------------------
    // Filter predictor and store of pending filter results
    // ------------------------------------------------------------------------
    class median_scoreboard;
        period_t        period;
        rank_t          rank;
        sample_t        batch_buf[BATCH_N];
        int unsigned    fill;
        time_t          last_taken_ms;
        sample_t        filt_hold;
        sample_t        raw_hold;
        filter_result_t pending_q[$];
        int             errors;
        int             ticks;
        int             taken_cnt;
        int             batches;

        function new();
            period        = PERIOD_RESET;
            rank          = RANK_RESET;
            fill          = 0;
            last_taken_ms = '0;
            filt_hold     = '0;
            raw_hold      = '0;
            errors        = 0;
            ticks         = 0;
            taken_cnt     = 0;
            batches       = 0;
            foreach (batch_buf[i]) batch_buf[i] = '0;
        endfunction

        function void write_reg(cfg_idx_t idx, cfg_data_t data);
            if (idx == REG_SAMPLE_PERIOD)
                period = period_t'(data);
            else if (idx == REG_SELECT_RANK)
                rank = data[RANK_W-1:0];
        endfunction

        // Insertion sort of a copy of the batch, then pick the clamped rank.
        function sample_t ranked_pick();
            sample_t s[BATCH_N];
            sample_t key;
            int      j;
            int      k;
            s = batch_buf;
            for (int i = 1; i < BATCH_N; i++)
            begin
                key = s[i];
                j   = i;
                while (j > 0 && s[j-1] > key)
                begin
                    s[j] = s[j-1];
                    j--;
                end
                s[j] = key;
            end
            k = (int'(rank) >= BATCH_N) ? BATCH_N - 1 : int'(rank);
            return s[k];
        endfunction

        function void note_tick(time_t now_ms, sample_t rd);
            filter_result_t exp_res;
            time_t          elapsed;
            elapsed       = now_ms - last_taken_ms;
            exp_res.taken = 1'b0;
            exp_res.done  = 1'b0;
            if (elapsed >= time_t'(period))
            begin
                exp_res.taken = 1'b1;
                last_taken_ms = now_ms;
                raw_hold      = rd;
                taken_cnt++;
                if (fill >= BATCH_N)
                begin
                    filt_hold    = ranked_pick();
                    fill         = 0;
                    exp_res.done = 1'b1;
                    batches++;
                end
                else
                begin
                    batch_buf[fill] = rd;
                    fill++;
                end
            end
            exp_res.filt = filt_hold;
            exp_res.raw  = raw_hold;
            pending_q.push_back(exp_res);
            ticks++;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(sample_t filt, sample_t raw, logic taken, logic done);
            filter_result_t want;
            if (pending_q.size() == 0)
            begin
                report("result beat with no tick pending");
                return;
            end
            want = pending_q.pop_front();
            if (filt !== want.filt)
                report($sformatf("filtered_value got %0d want %0d", filt, want.filt));
            if (raw !== want.raw)
                report($sformatf("raw_value got %0d want %0d", raw, want.raw));
            if (taken !== want.taken)
                report($sformatf("sample_taken got %b want %b", taken, want.taken));
            if (done !== want.done)
                report($sformatf("batch_done got %b want %b", done, want.done));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      tick_valid   = 1'b0;
    logic      tick_ready;
    time_t     time_ms      = '0;
    sample_t   reading      = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    sample_t   filtered_value;
    sample_t   raw_value;
    logic      sample_taken;
    logic      batch_done;
    logic      cfg_valid    = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index    = '0;
    cfg_data_t cfg_data     = '0;

    median_scoreboard sb = new();

    // Tick time of the most recent beat; random steps walk forward from it.
    time_t now_ms      = '0;
    // Per-phase switches that turn off idling on one side.
    bit    src_steady  = 1'b0;
    bit    sink_steady = 1'b0;

    block_median_sample_filter #(
        .BATCH_SIZE(BATCH_N)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_ready    (tick_ready),
        .time_ms       (time_ms),
        .reading       (reading),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .filtered_value(filtered_value),
        .raw_value     (raw_value),
        .sample_taken  (sample_taken),
        .batch_done    (batch_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // Mostly back-to-back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Favor a narrow band so batches hold ties; mix in extremes and full range.
    function automatic sample_t pick_reading();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return sample_t'(int'($urandom_range(0, 6)) - 3);
        if (r < 45)
            return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        return sample_t'($urandom);
    endfunction

    // Step the clock of the ticks: mostly just past the period so samples get
    // taken and batches close, some short of it, plain 1 ms steps, and noise.
    function automatic time_t next_time(time_t cur, period_t per);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return cur + time_t'(per) + time_t'($urandom_range(0, 3));
        if (r < 65 && per > 1)
            return cur + time_t'($urandom_range(0, int'(per) - 1));
        if (r < 88)
            return cur + 1;
        return time_t'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one tick beat and hold it until accepted. Drop valid only when a
    // gap is taken, so a follow-on beat keeps valid high without a glitch.
    task automatic send_tick(input time_t t, input sample_t rd);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        time_ms    <= t;
        reading    <= rd;
        now_ms      = t;
        do
            @(posedge clk);
        while (!tick_ready);
    endtask

    // Lower tick valid and wait for the next clock edge.
    task automatic idle_tick();
        tick_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off the sender until every pending result beat has come back.
    task automatic drain_results();
        idle_tick();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; only called with no tick in flight.
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random back-pressure, long stalls now and then
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                result_ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!sink_steady)
                    hold = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: note each accepted tick beat, check each accepted result beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(filtered_value, raw_value, sample_taken, batch_done);
            if (tick_valid && tick_ready)
                sb.note_tick(time_ms, reading);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        period_t per_tab[PHASES];
        rank_t   rank_tab[PHASES];
        int      settings;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (period 1000, rank 2): below the period, exactly on
        // it, and one full batch with both reading extremes, then the close.
        send_tick(32'd0,    sample_t'(5));
        send_tick(32'd999,  sample_t'(17));
        send_tick(32'd1000, SAMPLE_MIN);
        send_tick(32'd2000, SAMPLE_MAX);
        send_tick(32'd3000, sample_t'(40));
        send_tick(32'd3001, sample_t'(100));
        send_tick(32'd4000, sample_t'(-7));
        send_tick(32'd5000, sample_t'(1));
        send_tick(32'd6000, sample_t'(9));
        drain_results();

        // Zero period takes every tick; rank 15 clamps to the top; ties in the
        // batch; writes to unused indexes must leave the registers alone.
        write_reg(REG_SAMPLE_PERIOD, cfg_data_t'(0));
        write_reg(REG_SELECT_RANK, cfg_data_t'(16'hFFFF));
        write_reg(REG_TOP, cfg_data_t'(16'hFFFF));
        write_reg(cfg_idx_t'(REG_SELECT_RANK + 1), cfg_data_t'(0));
        send_tick(32'd6000, sample_t'(3));
        send_tick(32'd6000, sample_t'(3));
        send_tick(32'd6000, sample_t'(-3));
        send_tick(32'd6000, sample_t'(3));
        send_tick(32'd6000, sample_t'(-3));
        send_tick(32'd6000, sample_t'(8));
        drain_results();

        // Longest period across the 32-bit wrap: land exactly on the period
        // after the wrap, then well short of it.
        write_reg(REG_SAMPLE_PERIOD, cfg_data_t'(16'hFFFF));
        write_reg(REG_SELECT_RANK, cfg_data_t'(0));
        send_tick(32'hFFFF_FF00, sample_t'(-100));
        send_tick(32'h0000_FEFF, sample_t'(50));
        send_tick(32'h0000_FF00, sample_t'(12));
        send_tick(32'hFFFF_FFFF, sample_t'(0));

        // Random phases, each with its own period and rank.
        per_tab  = '{period_t'(1000), period_t'(0), period_t'(16'hFFFF), period_t'(1),
                     period_t'($urandom_range(2, 40)), period_t'($urandom),
                     period_t'(3), period_t'($urandom_range(100, 5000))};
        rank_tab = '{rank_t'(2), rank_t'(15), rank_t'(0), rank_t'(4),
                     rank_t'(5), rank_t'($urandom), rank_t'(1), rank_t'($urandom)};
        settings = 3;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_reg(REG_SAMPLE_PERIOD, cfg_data_t'(per_tab[ph]));
            write_reg(REG_SELECT_RANK, cfg_data_t'({12'($urandom), rank_tab[ph]}));
            if (ph % 3 == 1)
                write_reg(cfg_idx_t'($urandom_range(REG_SELECT_RANK + 1, REG_TOP)),
                          cfg_data_t'($urandom));
            settings++;
            // Leave one side free of idling in some phases.
            src_steady  = (ph % 4 == 2);
            sink_steady = (ph % 4 == 3);
            for (int k = 0; k < TICKS_PER_PHASE; k++)
            begin
                // Hold the sender until the result queue empties.
                if (ph % 3 == 0 && k == TICKS_PER_PHASE / 2)
                    drain_results();
                send_tick(next_time(now_ms, per_tab[ph]), pick_reading());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Covered %0d ticks over %0d period/rank settings:", sb.ticks, settings);
        $display("  %0d samples taken, %0d batches closed", sb.taken_cnt, sb.batches);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
